>>> src/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
// Used by qau_pass and quaternion_arithmetic_unit; has no dependencies.
package qau_pkg;

    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 30;
    localparam int NUM_SLOTS      = 16;

    typedef enum logic [2:0] {
        MODE_MUL     = 3'd0,
        MODE_ROTATE  = 3'd1,
        MODE_ADD     = 3'd2,
        MODE_SUB     = 3'd3,
        MODE_CONJ    = 3'd4,
        MODE_SCALE   = 3'd5,
        MODE_NORMSQ  = 3'd6,
        MODE_COMPARE = 3'd7
    } mode_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] neg;
        logic                 use_direct;
        logic [3:0]           clear;
    } pass_ctl_t;

    // Hamilton product P*Q: product slot 4*c+k feeds result component c.
    localparam logic [NUM_SLOTS-1:0][1:0] HAM_P = {
        2'd2, 2'd1, 2'd3, 2'd0,
        2'd1, 2'd3, 2'd2, 2'd0,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd3, 2'd2, 2'd1, 2'd0
    };
    localparam logic [NUM_SLOTS-1:0][1:0] HAM_Q = {
        2'd1, 2'd2, 2'd0, 2'd3,
        2'd3, 2'd1, 2'd0, 2'd2,
        2'd2, 2'd3, 2'd0, 2'd1,
        2'd3, 2'd2, 2'd1, 2'd0
    };
    localparam logic [NUM_SLOTS-1:0] HAM_NEG = 16'h888E;

    localparam logic [3:0] CLEAR_SCALAR = 4'b0001;

endpackage

>>> src/qau_pass.sv
// One multiply-accumulate pass: sixteen rounded products summed in groups of four,
// saturated per component, in four pipeline stages. Depends on qau_pkg.
module qau_pass
    import qau_pkg::*;
#(
    parameter int CW  = COMP_WIDTH_DEF,
    parameter int FB  = FRAC_BITS_DEF,
    parameter int SBW = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [NUM_SLOTS-1:0][CW-1:0]  in_x,
    input  logic [NUM_SLOTS-1:0][CW-1:0]  in_y,
    input  pass_ctl_t                     in_ctl,
    input  logic [3:0][CW:0]              in_direct,
    input  logic [SBW-1:0]                in_sb,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0][CW-1:0]            out_res,
    output logic                          out_ovf,
    output logic                          out_less,
    output logic [SBW-1:0]                out_sb
);

    localparam int LW = CW / 2;
    localparam int HW = CW - LW;
    localparam int PW = 2 * CW + 1;
    localparam int AW = PW + 2;
    localparam int DW = CW + 1;
    localparam logic signed [PW-1:0] RND = PW'(1) << (FB - 1);
    localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [2*HW-1:0] hh_next [NUM_SLOTS];
    logic signed [2*HW-1:0] hh_reg  [NUM_SLOTS];
    logic signed [CW:0]     hl_next [NUM_SLOTS];
    logic signed [CW:0]     hl_reg  [NUM_SLOTS];
    logic signed [CW:0]     lh_next [NUM_SLOTS];
    logic signed [CW:0]     lh_reg  [NUM_SLOTS];
    logic [2*LW-1:0]        ll_next [NUM_SLOTS];
    logic [2*LW-1:0]        ll_reg  [NUM_SLOTS];
    pass_ctl_t              ctl1_reg, ctl2_reg, ctl3_reg;
    logic [3:0][DW-1:0]     dir1_reg, dir2_reg;
    logic [SBW-1:0]         sb1_reg, sb2_reg, sb3_reg, sb4_reg;

    logic signed [PW-1:0]   prod_s  [NUM_SLOTS];
    logic signed [PW-1:0]   rp_next [NUM_SLOTS];
    logic signed [PW-1:0]   rp_reg  [NUM_SLOTS];

    logic signed [AW-1:0]   term_s   [NUM_SLOTS];
    logic signed [AW-1:0]   acc_next [4];
    logic signed [AW-1:0]   acc_reg  [4];

    logic [3:0][CW-1:0]     res_next, res_reg;
    logic [3:0]             sat_ovf;
    logic                   ovf_reg, less_reg, less_next;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            hh_next[i] = $signed(in_x[i][CW-1:LW]) * $signed(in_y[i][CW-1:LW]);
            hl_next[i] = $signed(in_x[i][CW-1:LW]) * $signed({1'b0, in_y[i][LW-1:0]});
            lh_next[i] = $signed({1'b0, in_x[i][LW-1:0]}) * $signed(in_y[i][CW-1:LW]);
            ll_next[i] = in_x[i][LW-1:0] * in_y[i][LW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            prod_s[i] = (PW'(hh_reg[i]) <<< (2 * LW))
                      + ((PW'(hl_reg[i]) + PW'(lh_reg[i])) <<< LW)
                      + PW'($signed({1'b0, ll_reg[i]})) + RND;
            rp_next[i] = prod_s[i] >>> FB;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            term_s[i] = ctl2_reg.neg[i] ? -AW'(rp_reg[i]) : AW'(rp_reg[i]);
        end
        for (int c = 0; c < 4; c++)
        begin
            if (ctl2_reg.use_direct)
            begin
                acc_next[c] = AW'($signed(dir2_reg[c]));
            end
            else
            begin
                acc_next[c] = term_s[4*c] + term_s[4*c+1] + term_s[4*c+2] + term_s[4*c+3];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (&acc_reg[c][AW-1:CW-1] || ~|acc_reg[c][AW-1:CW-1])
            begin
                sat_ovf[c]  = 1'b0;
                res_next[c] = acc_reg[c][CW-1:0];
            end
            else
            begin
                sat_ovf[c]  = 1'b1;
                res_next[c] = acc_reg[c][AW-1] ? SAT_MIN : SAT_MAX;
            end
            if (ctl3_reg.clear[c])
            begin
                res_next[c] = '0;
            end
        end
        less_next = acc_reg[0] < acc_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            lh_reg   <= lh_next;
            ll_reg   <= ll_next;
            ctl1_reg <= in_ctl;
            dir1_reg <= in_direct;
            sb1_reg  <= in_sb;
        end
        if (en2)
        begin
            rp_reg   <= rp_next;
            ctl2_reg <= ctl1_reg;
            dir2_reg <= dir1_reg;
            sb2_reg  <= sb1_reg;
        end
        if (en3)
        begin
            acc_reg  <= acc_next;
            ctl3_reg <= ctl2_reg;
            sb3_reg  <= sb2_reg;
        end
        if (en4)
        begin
            res_reg  <= res_next;
            ovf_reg  <= |sat_ovf;
            less_reg <= less_next;
            sb4_reg  <= sb3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = res_reg;
    assign out_ovf   = ovf_reg;
    assign out_less  = less_reg;
    assign out_sb    = sb4_reg;

endmodule

>>> src/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: two qau_pass pipelines in series, the second used
// for the conjugate product of a rotation. Depends on qau_pkg and qau_pass.
// Both four-stage multiply-accumulate passes lie on the path of every operation.
// Throughput: one item per cycle until a held output fills every stage; bubbles refill.
// Reset clears every stage valid bit; data registers are not reset.
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int  COMP_WIDTH  = COMP_WIDTH_DEF,
    parameter int  FRAC_BITS   = FRAC_BITS_DEF,
    localparam int OUT_TDATA_W = ((4 * COMP_WIDTH + 3 + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [8*COMP_WIDTH-1:0] s_axis_tdata,
    // mode
    input  logic [2:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // r_w, r_x, r_y, r_z, norm_less, exact_equal, overflow, zero fill
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int CW      = COMP_WIDTH;
    localparam int DW      = CW + 1;
    localparam int OUT_PAD = OUT_TDATA_W - 4 * CW - 3;
    localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        mode_t              mode;
        logic               eq;
        logic               conj_ovf;
        logic [3:0][CW-1:0] cq;
    } sb1_t;

    typedef struct packed {
        logic ovf1;
        logic less;
        logic eq;
    } sb2_t;

    mode_t                       mode_in;
    logic [3:0][CW-1:0]          a_q, b_q;
    logic [NUM_SLOTS-1:0][CW-1:0] p1_x, p1_y, p2_x, p2_y;
    pass_ctl_t                   p1_ctl, p2_ctl;
    logic [3:0][DW-1:0]          p1_dir, p2_dir;
    sb1_t                        sb1_in, p1_sb;
    sb2_t                        sb2_in, p2_sb;
    logic                        p1_valid, p1_ovf, p1_less, p2_ready;
    logic [3:0][CW-1:0]          p1_res, p2_res;
    logic                        p2_valid, p2_ovf;

    assign mode_in = mode_t'(s_axis_tuser);
    assign a_q     = s_axis_tdata[4*CW-1:0];
    assign b_q     = s_axis_tdata[8*CW-1:4*CW];

    always_comb
    begin
        p1_x   = '0;
        p1_y   = '0;
        p1_dir = '0;
        p1_ctl = '0;
        case (mode_in)
            MODE_MUL:
            begin
                p1_ctl.neg = HAM_NEG;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    p1_x[i] = a_q[HAM_P[i]];
                    p1_y[i] = b_q[HAM_Q[i]];
                end
            end
            MODE_ROTATE:
            begin
                p1_ctl.neg = HAM_NEG;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    p1_x[i] = a_q[HAM_P[i]];
                    p1_y[i] = (HAM_Q[i] == 2'd0) ? '0 : b_q[HAM_Q[i]];
                end
            end
            MODE_ADD:
            begin
                p1_ctl.use_direct = 1'b1;
                for (int c = 0; c < 4; c++)
                begin
                    p1_dir[c] = DW'($signed(a_q[c])) + DW'($signed(b_q[c]));
                end
            end
            MODE_SUB:
            begin
                p1_ctl.use_direct = 1'b1;
                for (int c = 0; c < 4; c++)
                begin
                    p1_dir[c] = DW'($signed(a_q[c])) - DW'($signed(b_q[c]));
                end
            end
            MODE_CONJ:
            begin
                p1_ctl.use_direct = 1'b1;
                p1_dir[0] = DW'($signed(a_q[0]));
                for (int c = 1; c < 4; c++)
                begin
                    p1_dir[c] = -DW'($signed(a_q[c]));
                end
            end
            MODE_SCALE:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    p1_x[4*c] = a_q[c];
                    p1_y[4*c] = b_q[0];
                end
            end
            MODE_NORMSQ:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    p1_x[k] = a_q[k];
                    p1_y[k] = a_q[k];
                end
            end
            MODE_COMPARE:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    p1_x[k]   = a_q[k];
                    p1_y[k]   = a_q[k];
                    p1_x[4+k] = b_q[k];
                    p1_y[4+k] = b_q[k];
                end
            end
            default:
            begin
                p1_ctl = '0;
            end
        endcase
    end

    // The conjugate of A is needed again by the second pass of a rotation.
    always_comb
    begin
        sb1_in.mode     = mode_in;
        sb1_in.eq       = (mode_in == MODE_COMPARE) && (a_q == b_q);
        sb1_in.conj_ovf = 1'b0;
        sb1_in.cq[0]    = a_q[0];
        for (int k = 1; k < 4; k++)
        begin
            if (a_q[k] == SAT_MIN)
            begin
                sb1_in.cq[k]    = SAT_MAX;
                sb1_in.conj_ovf = 1'b1;
            end
            else
            begin
                sb1_in.cq[k] = CW'(-$signed(a_q[k]));
            end
        end
    end

    qau_pass #(
        .CW  (CW),
        .FB  (FRAC_BITS),
        .SBW ($bits(sb1_t))
    ) u_pass1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (p1_x),
        .in_y      (p1_y),
        .in_ctl    (p1_ctl),
        .in_direct (p1_dir),
        .in_sb     (sb1_in),
        .out_valid (p1_valid),
        .out_ready (p2_ready),
        .out_res   (p1_res),
        .out_ovf   (p1_ovf),
        .out_less  (p1_less),
        .out_sb    (p1_sb)
    );

    always_comb
    begin
        p2_x        = '0;
        p2_y        = '0;
        p2_dir      = '0;
        p2_ctl      = '0;
        sb2_in.eq   = p1_sb.eq;
        sb2_in.less = (p1_sb.mode == MODE_COMPARE) && p1_less;
        if (p1_sb.mode == MODE_ROTATE)
        begin
            p2_ctl.neg   = HAM_NEG;
            p2_ctl.clear = CLEAR_SCALAR;
            sb2_in.ovf1  = p1_ovf || p1_sb.conj_ovf;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                p2_x[i] = p1_res[HAM_P[i]];
                p2_y[i] = p1_sb.cq[HAM_Q[i]];
            end
        end
        else
        begin
            p2_ctl.use_direct = 1'b1;
            sb2_in.ovf1       = (p1_sb.mode != MODE_COMPARE) && p1_ovf;
            for (int c = 0; c < 4; c++)
            begin
                p2_dir[c] = (p1_sb.mode == MODE_COMPARE) ? '0 : DW'($signed(p1_res[c]));
            end
        end
    end

    qau_pass #(
        .CW  (CW),
        .FB  (FRAC_BITS),
        .SBW ($bits(sb2_t))
    ) u_pass2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid),
        .in_ready  (p2_ready),
        .in_x      (p2_x),
        .in_y      (p2_y),
        .in_ctl    (p2_ctl),
        .in_direct (p2_dir),
        .in_sb     (sb2_in),
        .out_valid (p2_valid),
        .out_ready (m_axis_tready),
        .out_res   (p2_res),
        .out_ovf   (p2_ovf),
        .out_less  (),
        .out_sb    (p2_sb)
    );

    assign m_axis_tvalid = p2_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, p2_ovf || p2_sb.ovf1, p2_sb.eq, p2_sb.less, p2_res};

    // The input side can only stall when the whole pipeline is full behind a held result.
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output was not held");

    // Compare flags come only with a cleared result and no overflow.
    a_compare_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[4*CW] || m_axis_tdata[4*CW+1]))
        |-> (m_axis_tdata[4*CW-1:0] == '0 && !m_axis_tdata[4*CW+2]))
        else $error("compare flags set with a nonzero result or overflow");

endmodule
